FILE: hdl/rsm_pkg.sv
`timescale 1ns / 1ps

package rsm_pkg;

	typedef logic [2:0] mode_t;
	typedef logic [3:0] event_t;
	typedef logic [3:0] fault_t;
	typedef logic [4:0] reason_t;

	// modes
	localparam mode_t MODE_DISABLED = 3'd0;
	localparam mode_t MODE_IDLE     = 3'd1;
	localparam mode_t MODE_ACTIVE   = 3'd2;
	localparam mode_t MODE_HOLD     = 3'd3;
	localparam mode_t MODE_FAULT    = 3'd4;
	localparam mode_t MODE_ESTOP    = 3'd5;

	// events
	localparam event_t EV_BOOT          = 4'd0;
	localparam event_t EV_ACTIVATE      = 4'd1;
	localparam event_t EV_DEACTIVATE    = 4'd2;
	localparam event_t EV_FAULT         = 4'd3;
	localparam event_t EV_FAULT_CLEARED = 4'd4;
	localparam event_t EV_TIMEOUT       = 4'd5;
	localparam event_t EV_ILK_READY     = 4'd6;
	localparam event_t EV_ILK_LOST      = 4'd7;
	localparam event_t EV_HOLD          = 4'd8;
	localparam event_t EV_RESUME        = 4'd9;
	localparam event_t EV_ESTOP         = 4'd10;
	localparam event_t EV_ESTOP_RESET   = 4'd11;
	localparam event_t EV_SET_FAULT     = 4'd12;

	// fault codes
	localparam fault_t FC_NONE     = 4'd0;
	localparam fault_t FC_WATCHDOG = 4'd1;
	localparam fault_t FC_ILK_LOST = 4'd2;

	// reasons
	localparam reason_t RSN_ESTOP_LATCHED      = 5'd0;
	localparam reason_t RSN_BOOT_DONE          = 5'd1;
	localparam reason_t RSN_ALREADY_DISABLED   = 5'd2;
	localparam reason_t RSN_MUST_BOOT          = 5'd3;
	localparam reason_t RSN_NOT_IN_ESTOP       = 5'd4;
	localparam reason_t RSN_ILK_TO_ACTIVATE    = 5'd5;
	localparam reason_t RSN_ACTIVATED          = 5'd6;
	localparam reason_t RSN_DIS_FROM_IDLE      = 5'd7;
	localparam reason_t RSN_FAULT_IDLE         = 5'd8;
	localparam reason_t RSN_DEACTIVATED        = 5'd9;
	localparam reason_t RSN_TIMEOUT_HOLD       = 5'd10;
	localparam reason_t RSN_ILK_LOST_HOLD      = 5'd11;
	localparam reason_t RSN_FAULT_ACTIVE       = 5'd12;
	localparam reason_t RSN_EXPLICIT_HOLD      = 5'd13;
	localparam reason_t RSN_RESUME_NO_ILK      = 5'd14;
	localparam reason_t RSN_HOLD_ACK           = 5'd15;
	localparam reason_t RSN_CLEAR_FAULT_FIRST  = 5'd16;
	localparam reason_t RSN_DIS_FROM_HOLD      = 5'd17;
	localparam reason_t RSN_FAULT_HOLD         = 5'd18;
	localparam reason_t RSN_ILK_BACK_HOLDING   = 5'd19;
	localparam reason_t RSN_FAULT_CLEARED      = 5'd20;
	localparam reason_t RSN_DIS_FROM_FAULT     = 5'd21;
	localparam reason_t RSN_ERESET_NO_ILK      = 5'd22;
	localparam reason_t RSN_ERESET_IDLE        = 5'd23;
	localparam reason_t RSN_ESTOP_NEEDS_RESET  = 5'd24;
	localparam reason_t RSN_ILK_UPDATED        = 5'd25;
	localparam reason_t RSN_NOT_ALLOWED        = 5'd26;
	localparam reason_t RSN_SET_FAULT          = 5'd27;

	typedef struct packed {
		mode_t  mode;
		logic   ilk;
		fault_t fault;
	} rsm_state_t;

	typedef struct packed {
		logic    accepted;
		mode_t   from_mode;
		mode_t   to_mode;
		reason_t reason_code;
		logic    output_permit;
		logic    interlock_now;
		fault_t  fault_now;
	} rsm_result_t;

endpackage

FILE: hdl/rsm_if.sv
`timescale 1ns / 1ps

interface rsm_evt_if;
	logic       valid;
	logic       ready;
	logic [3:0] event_req;
	logic [3:0] fault_code_in;

	modport source(output valid, output event_req, output fault_code_in, input ready);
	modport sink(input valid, input event_req, input fault_code_in, output ready);
endinterface

interface rsm_res_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic [2:0] from_mode;
	logic [2:0] to_mode;
	logic [4:0] reason_code;
	logic       output_permit;
	logic       interlock_now;
	logic [3:0] fault_now;

	modport source(output valid, output accepted, output from_mode, output to_mode,
		output reason_code, output output_permit, output interlock_now,
		output fault_now, input ready);
	modport sink(input valid, input accepted, input from_mode, input to_mode,
		input reason_code, input output_permit, input interlock_now,
		input fault_now, output ready);
endinterface

FILE: hdl/rsm_mode_logic.sv
`timescale 1ns / 1ps

module rsm_mode_logic import rsm_pkg::*; (
	input  rsm_state_t  cur,
	input  event_t      event_req,
	input  fault_t      fault_code_in,
	output rsm_state_t  nxt,
	output rsm_result_t res
);

	logic    acc;
	mode_t   to;
	reason_t rsn;
	logic    hit;
	logic    ilk;
	fault_t  flt;

	always_comb begin
		acc = 1'b0;
		to  = cur.mode;
		rsn = RSN_NOT_ALLOWED;
		hit = 1'b0;
		ilk = cur.ilk;
		flt = cur.fault;

		if (event_req == EV_SET_FAULT) begin
			flt = fault_code_in;
			acc = 1'b1;
			rsn = RSN_SET_FAULT;
		end else begin
			if (event_req == EV_ILK_READY)
				ilk = 1'b1;
			else if (event_req == EV_ILK_LOST)
				ilk = 1'b0;

			if (event_req == EV_ESTOP) begin
				flt = FC_NONE;
				acc = 1'b1;
				to  = MODE_ESTOP;
				rsn = RSN_ESTOP_LATCHED;
				hit = 1'b1;
			end else begin
				unique case (cur.mode)
					MODE_DISABLED: begin
						hit = 1'b1;
						if (event_req == EV_BOOT) begin
							acc = 1'b1; to = MODE_IDLE; rsn = RSN_BOOT_DONE;
						end else if (event_req == EV_DEACTIVATE) begin
							acc = 1'b1; to = MODE_DISABLED; rsn = RSN_ALREADY_DISABLED;
						end else if (event_req == EV_ACTIVATE) begin
							rsn = RSN_MUST_BOOT;
						end else if (event_req == EV_ESTOP_RESET) begin
							rsn = RSN_NOT_IN_ESTOP;
						end else begin
							hit = 1'b0;
						end
					end
					MODE_IDLE: begin
						hit = 1'b1;
						if (event_req == EV_ACTIVATE) begin
							if (!ilk) begin
								rsn = RSN_ILK_TO_ACTIVATE;
							end else begin
								flt = FC_NONE;
								acc = 1'b1; to = MODE_ACTIVE; rsn = RSN_ACTIVATED;
							end
						end else if (event_req == EV_DEACTIVATE) begin
							acc = 1'b1; to = MODE_DISABLED; rsn = RSN_DIS_FROM_IDLE;
						end else if (event_req == EV_FAULT) begin
							acc = 1'b1; to = MODE_FAULT; rsn = RSN_FAULT_IDLE;
						end else begin
							hit = 1'b0;
						end
					end
					MODE_ACTIVE: begin
						hit = 1'b1;
						if (event_req == EV_DEACTIVATE) begin
							acc = 1'b1; to = MODE_IDLE; rsn = RSN_DEACTIVATED;
						end else if (event_req == EV_TIMEOUT) begin
							flt = FC_WATCHDOG;
							acc = 1'b1; to = MODE_HOLD; rsn = RSN_TIMEOUT_HOLD;
						end else if (event_req == EV_ILK_LOST) begin
							flt = FC_ILK_LOST;
							acc = 1'b1; to = MODE_HOLD; rsn = RSN_ILK_LOST_HOLD;
						end else if (event_req == EV_FAULT) begin
							acc = 1'b1; to = MODE_FAULT; rsn = RSN_FAULT_ACTIVE;
						end else if (event_req == EV_HOLD) begin
							acc = 1'b1; to = MODE_HOLD; rsn = RSN_EXPLICIT_HOLD;
						end else begin
							hit = 1'b0;
						end
					end
					MODE_HOLD: begin
						hit = 1'b1;
						if (event_req == EV_RESUME) begin
							if (!ilk) begin
								rsn = RSN_RESUME_NO_ILK;
							end else if (cur.fault == FC_NONE || cur.fault == FC_WATCHDOG ||
								cur.fault == FC_ILK_LOST) begin
								flt = FC_NONE;
								acc = 1'b1; to = MODE_IDLE; rsn = RSN_HOLD_ACK;
							end else begin
								rsn = RSN_CLEAR_FAULT_FIRST;
							end
						end else if (event_req == EV_DEACTIVATE) begin
							flt = FC_NONE;
							acc = 1'b1; to = MODE_DISABLED; rsn = RSN_DIS_FROM_HOLD;
						end else if (event_req == EV_FAULT) begin
							acc = 1'b1; to = MODE_FAULT; rsn = RSN_FAULT_HOLD;
						end else if (event_req == EV_ILK_READY) begin
							acc = 1'b1; to = MODE_HOLD; rsn = RSN_ILK_BACK_HOLDING;
						end else begin
							hit = 1'b0;
						end
					end
					MODE_FAULT: begin
						hit = 1'b1;
						if (event_req == EV_FAULT_CLEARED) begin
							flt = FC_NONE;
							acc = 1'b1; to = MODE_IDLE; rsn = RSN_FAULT_CLEARED;
						end else if (event_req == EV_DEACTIVATE) begin
							flt = FC_NONE;
							acc = 1'b1; to = MODE_DISABLED; rsn = RSN_DIS_FROM_FAULT;
						end else begin
							hit = 1'b0;
						end
					end
					MODE_ESTOP: begin
						hit = 1'b1;
						if (event_req == EV_ESTOP_RESET) begin
							if (!ilk) begin
								rsn = RSN_ERESET_NO_ILK;
							end else begin
								flt = FC_NONE;
								acc = 1'b1; to = MODE_IDLE; rsn = RSN_ERESET_IDLE;
							end
						end else if (event_req == EV_ACTIVATE || event_req == EV_RESUME) begin
							rsn = RSN_ESTOP_NEEDS_RESET;
						end else begin
							hit = 1'b0;
						end
					end
					default: begin
						hit = 1'b0;
					end
				endcase
			end

			// fall-through for events no mode rule claimed
			if (!hit) begin
				if (event_req == EV_ILK_READY || event_req == EV_ILK_LOST) begin
					acc = 1'b1;
					to  = cur.mode;
					rsn = RSN_ILK_UPDATED;
				end else begin
					acc = 1'b0;
					to  = cur.mode;
					rsn = RSN_NOT_ALLOWED;
				end
			end
		end
	end

	assign nxt.mode  = to;
	assign nxt.ilk   = ilk;
	assign nxt.fault = flt;

	assign res.accepted      = acc;
	assign res.from_mode     = cur.mode;
	assign res.to_mode       = to;
	assign res.reason_code   = rsn;
	assign res.output_permit = (to == MODE_ACTIVE) && ilk;
	assign res.interlock_now = ilk;
	assign res.fault_now     = flt;

endmodule

FILE: hdl/runtime_safety_mode_fsm.sv
`timescale 1ns / 1ps

// an event is held in the event register, then its result in the result register;
// throughput: one event per cycle unless res.ready stalls the result register; the
// mode rules are one combinational step between them; state updates in the same step
// reset: mode goes to disabled, interlock to not ready, fault code to none,
// and both pipeline stages are emptied

module runtime_safety_mode_fsm import rsm_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	rsm_evt_if.sink        evt,
	rsm_res_if.source      res
);

	logic        valid_s1;
	event_t      event_s1;
	fault_t      code_s1;
	logic        valid_s2;
	rsm_result_t res_s2;
	rsm_state_t  state_q;
	rsm_state_t  state_nxt;
	rsm_result_t res_nxt;
	logic        advance;

	// stage 1 moves on when the result register is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			event_s1 <= evt.event_req;
			code_s1  <= evt.fault_code_in;
		end
	end

	rsm_mode_logic u_logic (
		.cur           (state_q),
		.event_req     (event_s1),
		.fault_code_in (code_s1),
		.nxt           (state_nxt),
		.res           (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode  <= MODE_DISABLED;
			state_q.ilk   <= 1'b0;
			state_q.fault <= FC_NONE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign res.valid         = valid_s2;
	assign res.accepted      = res_s2.accepted;
	assign res.from_mode     = res_s2.from_mode;
	assign res.to_mode       = res_s2.to_mode;
	assign res.reason_code   = res_s2.reason_code;
	assign res.output_permit = res_s2.output_permit;
	assign res.interlock_now = res_s2.interlock_now;
	assign res.fault_now     = res_s2.fault_now;

endmodule
